[hdl/tens_pkg.sv]
`default_nettype none
package tens_pkg;

	// field widths
	localparam int VW   = 24;        // vertex coordinate
	localparam int EW   = 25;        // edge component
	localparam int PRW  = 2 * EW;    // edge product
	localparam int PW   = PRW + 1;   // first cross product component
	localparam int LO_W = 26;        // low slice of a split product operand
	localparam int HPW  = 2 * EW;    // high partial product
	localparam int LPW  = LO_W + 1 + EW; // low partial product
	localparam int WW   = 78;        // second cross product component
	localparam int HW   = WW / 2;    // half word for the leading-one search
	localparam int LW   = 7;         // bit length of a magnitude
	localparam int CW   = 30;        // normalized magnitude
	localparam int SQW  = 2 * CW;    // square of a normalized magnitude
	localparam int SW   = SQW + 2;   // sum of three squares
	localparam int RW   = SW / 2;    // square root
	localparam int RMW  = RW + 3;    // square root remainder
	localparam int FRAC = 14;        // Q1.14 fraction bits
	localparam int QW   = FRAC + 1;  // quotient bits
	localparam int NW   = CW + FRAC + 1; // dividend
	localparam int DRW  = RW + 1;    // divider remainder
	localparam int OW   = 16;        // normal output width

	localparam logic [QW-1:0] ONE_Q  = QW'(1 << FRAC);
	localparam logic [1:0]    LAST_E = 2'd2;

	typedef logic signed [EW-1:0] edge_t;

	typedef struct packed {
		edge_t x;
		edge_t y;
		edge_t z;
	} evec_t;

	typedef struct packed {
		logic [1:0] idx;
		evec_t      b;
	} side_t;

	typedef struct packed {
		logic  valid;
		side_t side;
	} tag_t;

	typedef struct packed {
		logic signed [WW-1:0] x;
		logic signed [WW-1:0] y;
		logic signed [WW-1:0] z;
	} wvec_t;

	typedef struct packed {
		logic [2:0]          neg;
		logic                deg;
		logic [2:0][CW-1:0]  c;
	} nvec_t;

endpackage
`default_nettype wire

[hdl/tens_issue.sv]
`default_nettype none
module tens_issue (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic signed [23:0]        ax,
	input  wire logic signed [23:0]        ay,
	input  wire logic signed [23:0]        az,
	input  wire logic signed [23:0]        bx,
	input  wire logic signed [23:0]        by,
	input  wire logic signed [23:0]        bz,
	input  wire logic signed [23:0]        cx,
	input  wire logic signed [23:0]        cy,
	input  wire logic signed [23:0]        cz,
	output tens_pkg::tag_t                 tag_s1,
	output tens_pkg::evec_t                a_s1
);
	import tens_pkg::*;

	logic       hold_q;
	logic [1:0] idx_q;
	evec_t      e0_q, e1_q, e2_q;
	evec_t      a_sel, b_sel;
	logic       take;
	logic       v_s1;
	side_t      sd_s1;

	// free the triangle buffer as its last edge leaves
	assign in_stall = hold_q && !(en && idx_q == LAST_E);
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (take) begin
			hold_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (en && hold_q) begin
			if (idx_q == LAST_E) hold_q <= 1'b0;
			idx_q <= idx_q + 2'd1;
		end
	end

	// edge vectors of the accepted triangle
	always_ff @(posedge clk) begin
		if (take) begin
			e0_q.x <= {bx[VW-1], bx} - {ax[VW-1], ax};
			e0_q.y <= {by[VW-1], by} - {ay[VW-1], ay};
			e0_q.z <= {bz[VW-1], bz} - {az[VW-1], az};
			e1_q.x <= {cx[VW-1], cx} - {bx[VW-1], bx};
			e1_q.y <= {cy[VW-1], cy} - {by[VW-1], by};
			e1_q.z <= {cz[VW-1], cz} - {bz[VW-1], bz};
			e2_q.x <= {ax[VW-1], ax} - {cx[VW-1], cx};
			e2_q.y <= {ay[VW-1], ay} - {cy[VW-1], cy};
			e2_q.z <= {az[VW-1], az} - {cz[VW-1], cz};
		end
	end

	// pick the edge and its successor
	always_comb begin
		unique case (idx_q)
			2'd0: begin
				b_sel = e0_q;
				a_sel = e1_q;
			end
			2'd1: begin
				b_sel = e1_q;
				a_sel = e2_q;
			end
			default: begin
				b_sel = e2_q;
				a_sel = e0_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= hold_q;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s1.idx <= idx_q;
			sd_s1.b   <= b_sel;
			a_s1      <= a_sel;
		end
	end

	assign tag_s1.valid = v_s1;
	assign tag_s1.side  = sd_s1;

endmodule
`default_nettype wire

[hdl/tens_cross.sv]
`default_nettype none
module tens_cross (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire tens_pkg::tag_t  tag_i,
	input  wire tens_pkg::evec_t a_i,
	output tens_pkg::tag_t       tag_o,
	output tens_pkg::wvec_t      w_o
);
	import tens_pkg::*;

	localparam int PSEL [6] = '{1, 2, 2, 0, 0, 1};
	localparam int BSEL [6] = '{2, 1, 0, 2, 1, 0};

	logic [5:1]             v_s;
	side_t                  sd_s1, sd_s2, sd_s3, sd_s4, sd_s5;
	logic signed [PRW-1:0]  pr_s1 [6];
	logic signed [PW-1:0]   p_s2 [3];
	logic signed [HPW-1:0]  hi_s3 [6];
	logic signed [LPW-1:0]  lo_s3 [6];
	logic signed [WW-1:0]   m_s4 [6];
	wvec_t                  w_s5;
	edge_t                  b2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s <= '0;
		else if (en) v_s <= {v_s[4:1], tag_i.valid};
	end

	assign b2[0] = sd_s2.b.x;
	assign b2[1] = sd_s2.b.y;
	assign b2[2] = sd_s2.b.z;

	always_ff @(posedge clk) begin
		if (en) begin
			// edge products
			sd_s1    <= tag_i.side;
			pr_s1[0] <= a_i.y * tag_i.side.b.z;
			pr_s1[1] <= a_i.z * tag_i.side.b.y;
			pr_s1[2] <= a_i.z * tag_i.side.b.x;
			pr_s1[3] <= a_i.x * tag_i.side.b.z;
			pr_s1[4] <= a_i.x * tag_i.side.b.y;
			pr_s1[5] <= a_i.y * tag_i.side.b.x;
			// first cross product
			sd_s2   <= sd_s1;
			p_s2[0] <= PW'(pr_s1[0]) - PW'(pr_s1[1]);
			p_s2[1] <= PW'(pr_s1[2]) - PW'(pr_s1[3]);
			p_s2[2] <= PW'(pr_s1[4]) - PW'(pr_s1[5]);
			// split each wide operand into a signed high and unsigned low slice
			sd_s3 <= sd_s2;
			for (int k = 0; k < 6; k++) begin
				hi_s3[k] <= $signed(p_s2[PSEL[k]][PW-1:LO_W]) * b2[BSEL[k]];
				lo_s3[k] <= $signed({1'b0, p_s2[PSEL[k]][LO_W-1:0]}) * b2[BSEL[k]];
			end
			// recombine the partial products
			sd_s4 <= sd_s3;
			for (int k = 0; k < 6; k++) begin
				m_s4[k] <= (WW'(hi_s3[k]) <<< LO_W) + WW'(lo_s3[k]);
			end
			// second cross product
			sd_s5  <= sd_s4;
			w_s5.x <= m_s4[0] - m_s4[1];
			w_s5.y <= m_s4[2] - m_s4[3];
			w_s5.z <= m_s4[4] - m_s4[5];
		end
	end

	assign tag_o.valid = v_s[5];
	assign tag_o.side  = sd_s5;
	assign w_o         = w_s5;

endmodule
`default_nettype wire

[hdl/tens_norm.sv]
`default_nettype none
module tens_norm (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire tens_pkg::tag_t           tag_i,
	input  wire tens_pkg::wvec_t          w_i,
	output tens_pkg::tag_t                tag_o,
	output tens_pkg::nvec_t               nv_o,
	output logic [tens_pkg::SW-1:0]       sum_o
);
	import tens_pkg::*;

	function automatic logic [5:0] msb_len(input logic [HW-1:0] x);
		logic [5:0] n;
		n = '0;
		for (int i = 0; i < HW; i++) begin
			if (x[i]) n = 6'(i + 1);
		end
		return n;
	endfunction

	logic [7:1]       v_s;
	side_t            sd_s1, sd_s2, sd_s3, sd_s4, sd_s5, sd_s6, sd_s7;
	logic [WW-1:0]    mag_s1 [3];
	logic [WW-1:0]    mag_s2 [3];
	logic [WW-1:0]    mag_s3 [3];
	logic [WW-1:0]    mag_s4 [3];
	logic [2:0]       neg_s1, neg_s2, neg_s3, neg_s4;
	logic [WW-1:0]    or_s2;
	logic [5:0]       lhi_s3, llo_s3;
	logic [LW-1:0]    len_s4;
	nvec_t            nv_s5, nv_s6, nv_s7;
	logic [SQW-1:0]   sq_s6 [3];
	logic [SW-1:0]    sum_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s <= '0;
		else if (en) v_s <= {v_s[6:1], tag_i.valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// magnitudes and signs
			sd_s1     <= tag_i.side;
			neg_s1    <= {w_i.z[WW-1], w_i.y[WW-1], w_i.x[WW-1]};
			mag_s1[0] <= w_i.x[WW-1] ? WW'(-w_i.x) : WW'(w_i.x);
			mag_s1[1] <= w_i.y[WW-1] ? WW'(-w_i.y) : WW'(w_i.y);
			mag_s1[2] <= w_i.z[WW-1] ? WW'(-w_i.z) : WW'(w_i.z);
			// the largest bit length is that of the OR
			sd_s2  <= sd_s1;
			neg_s2 <= neg_s1;
			mag_s2 <= mag_s1;
			or_s2  <= mag_s1[0] | mag_s1[1] | mag_s1[2];
			// leading one of each half
			sd_s3  <= sd_s2;
			neg_s3 <= neg_s2;
			mag_s3 <= mag_s2;
			lhi_s3 <= msb_len(or_s2[WW-1:HW]);
			llo_s3 <= msb_len(or_s2[HW-1:0]);
			// merge halves
			sd_s4  <= sd_s3;
			neg_s4 <= neg_s3;
			mag_s4 <= mag_s3;
			len_s4 <= (lhi_s3 != 6'd0) ? LW'(lhi_s3) + LW'(HW) : LW'(llo_s3);
			// bring the leading one to bit CW-1
			sd_s5      <= sd_s4;
			nv_s5.neg  <= neg_s4;
			nv_s5.deg  <= (len_s4 == '0);
			for (int k = 0; k < 3; k++) begin
				nv_s5.c[k] <= CW'({mag_s4[k], {CW{1'b0}}} >> len_s4);
			end
			// squares
			sd_s6 <= sd_s5;
			nv_s6 <= nv_s5;
			for (int k = 0; k < 3; k++) begin
				sq_s6[k] <= SQW'(nv_s5.c[k]) * SQW'(nv_s5.c[k]);
			end
			// sum of squares
			sd_s7  <= sd_s6;
			nv_s7  <= nv_s6;
			sum_s7 <= SW'(sq_s6[0]) + SW'(sq_s6[1]) + SW'(sq_s6[2]);
		end
	end

	assign tag_o.valid = v_s[7];
	assign tag_o.side  = sd_s7;
	assign nv_o        = nv_s7;
	assign sum_o       = sum_s7;

endmodule
`default_nettype wire

[hdl/tens_sqrt.sv]
`default_nettype none
module tens_sqrt (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire tens_pkg::tag_t           tag_i,
	input  wire tens_pkg::nvec_t          nv_i,
	input  wire logic [tens_pkg::SW-1:0]  sum_i,
	output tens_pkg::tag_t                tag_o,
	output tens_pkg::nvec_t               nv_o,
	output logic [tens_pkg::RW-1:0]       root_o
);
	import tens_pkg::*;

	logic              vld_s  [RW+1];
	side_t             sd_s   [RW+1];
	nvec_t             nv_s   [RW+1];
	logic [SW-1:0]     sv_s   [RW+1];
	logic [RMW-1:0]    rem_s  [RW+1];
	logic [RW-1:0]     root_s [RW+1];

	assign vld_s[0]  = tag_i.valid;
	assign sd_s[0]   = tag_i.side;
	assign nv_s[0]   = nv_i;
	assign sv_s[0]   = sum_i;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	// one root bit per stage, two radicand bits consumed each
	for (genvar k = 0; k < RW; k++) begin : g_step
		logic [RMW-1:0] rem_n;
		logic [RMW-1:0] trial;

		always_comb begin
			rem_n = {rem_s[k][RMW-3:0], sv_s[k][SW-1:SW-2]};
			trial = RMW'({root_s[k], 2'b01});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k+1] <= 1'b0;
			else if (en) vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_n >= trial) begin
					rem_s[k+1]  <= rem_n - trial;
					root_s[k+1] <= {root_s[k][RW-2:0], 1'b1};
				end else begin
					rem_s[k+1]  <= rem_n;
					root_s[k+1] <= {root_s[k][RW-2:0], 1'b0};
				end
				sv_s[k+1] <= {sv_s[k][SW-3:0], 2'b00};
				sd_s[k+1] <= sd_s[k];
				nv_s[k+1] <= nv_s[k];
			end
		end
	end

	assign tag_o.valid = vld_s[RW];
	assign tag_o.side  = sd_s[RW];
	assign nv_o        = nv_s[RW];
	assign root_o      = root_s[RW];

endmodule
`default_nettype wire

[hdl/tens_div.sv]
`default_nettype none
module tens_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire tens_pkg::tag_t                tag_i,
	input  wire tens_pkg::nvec_t               nv_i,
	input  wire logic [tens_pkg::RW-1:0]       root_i,
	output tens_pkg::tag_t                     tag_o,
	output logic [2:0]                         neg_o,
	output logic                               deg_o,
	output logic [2:0][tens_pkg::QW-1:0]       q_o
);
	import tens_pkg::*;

	logic                    vld_s  [QW+1];
	side_t                   sd_s   [QW+1];
	logic [2:0]              neg_s  [QW+1];
	logic                    deg_s  [QW+1];
	logic [RW-1:0]           root_s [QW+1];
	logic [2:0][DRW-1:0]     rem_s  [QW+1];
	logic [2:0][QW-1:0]      low_s  [QW+1];
	logic [2:0][QW-1:0]      q_s    [QW+1];
	logic [2:0][NW-1:0]      num;

	// rounded dividend; its top part is already below the root
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			num[j] = NW'({nv_i.c[j], {FRAC{1'b0}}}) + NW'(root_i >> 1);
		end
	end

	assign vld_s[0]  = tag_i.valid;
	assign sd_s[0]   = tag_i.side;
	assign neg_s[0]  = nv_i.neg;
	assign deg_s[0]  = nv_i.deg;
	assign root_s[0] = root_i;
	assign q_s[0]    = '0;
	for (genvar j = 0; j < 3; j++) begin : g_lane
		assign rem_s[0][j] = DRW'(num[j] >> QW);
		assign low_s[0][j] = num[j][QW-1:0];
	end

	// one quotient bit per stage in each lane
	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [2:0][DRW-1:0] rem_n;
		logic [DRW-1:0]      dvs;

		always_comb begin
			dvs = DRW'(root_s[k]);
			for (int j = 0; j < 3; j++) begin
				rem_n[j] = {rem_s[k][j][DRW-2:0], low_s[k][j][QW-1]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k+1] <= 1'b0;
			else if (en) vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < 3; j++) begin
					if (rem_n[j] >= dvs) begin
						rem_s[k+1][j] <= rem_n[j] - dvs;
						q_s[k+1][j]   <= {q_s[k][j][QW-2:0], 1'b1};
					end else begin
						rem_s[k+1][j] <= rem_n[j];
						q_s[k+1][j]   <= {q_s[k][j][QW-2:0], 1'b0};
					end
					low_s[k+1][j] <= {low_s[k][j][QW-2:0], 1'b0};
				end
				sd_s[k+1]   <= sd_s[k];
				neg_s[k+1]  <= neg_s[k];
				deg_s[k+1]  <= deg_s[k];
				root_s[k+1] <= root_s[k];
			end
		end
	end

	assign tag_o.valid = vld_s[QW];
	assign tag_o.side  = sd_s[QW];
	assign neg_o       = neg_s[QW];
	assign deg_o       = deg_s[QW];
	assign q_o         = q_s[QW];

endmodule
`default_nettype wire

[hdl/triangle_edge_normal_setup.sv]
// Triangle edge and edge-normal setup.
// Input channel: one triangle per transfer (in_valid / in_stall), three vertices
// ax..cz in signed Q12.12. Output channel: three results per triangle
// (out_valid / out_stall), one per edge in order 0, 1, 2, each with the exact
// edge vector, the unit in-plane edge normal in signed Q1.14, a degenerate flag
// and last on edge 2.
// Throughput: set by the single result channel, which carries three results per
// triangle; the edges enter the pipeline one per cycle while it does not stall,
// and a new triangle is taken as the last edge of the previous one leaves the
// input buffer. Pipeline stages: 1 issue, 5 cross product, 7 normalize, 31
// square root, 15 divide, 1 output stage; the three results of a triangle leave
// in edge order.
// Stall: while out_stall holds a valid result, the whole pipeline freezes;
// nothing is lost or repeated, and in_stall rises once the input buffer is full.
// Reset: arst_n clears all valid bits; the block then takes a triangle at once.
`default_nettype none
module triangle_edge_normal_setup (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic signed [23:0]  ax,
	input  wire logic signed [23:0]  ay,
	input  wire logic signed [23:0]  az,
	input  wire logic signed [23:0]  bx,
	input  wire logic signed [23:0]  by,
	input  wire logic signed [23:0]  bz,
	input  wire logic signed [23:0]  cx,
	input  wire logic signed [23:0]  cy,
	input  wire logic signed [23:0]  cz,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [1:0]               edge_index,
	output logic signed [24:0]       edge_x,
	output logic signed [24:0]       edge_y,
	output logic signed [24:0]       edge_z,
	output logic signed [15:0]       normal_x,
	output logic signed [15:0]       normal_y,
	output logic signed [15:0]       normal_z,
	output logic                     degenerate,
	output logic                     last
);
	import tens_pkg::*;

	function automatic logic signed [OW-1:0] signed_normal(input logic [QW-1:0] q,
		input logic neg, input logic deg);
		logic [QW-1:0] m;
		m = (q > ONE_Q) ? ONE_Q : q;
		if (deg) return '0;
		return neg ? -OW'(m) : OW'(m);
	endfunction

	logic               en;
	tag_t               tag_s1, tag_cr, tag_nm, tag_sq, tag_dv;
	evec_t              a_s1;
	wvec_t              w_cr;
	nvec_t              nv_nm, nv_sq;
	logic [SW-1:0]      sum_nm;
	logic [RW-1:0]      root_sq;
	logic [2:0]         neg_dv;
	logic               deg_dv;
	logic [2:0][QW-1:0] q_dv;

	// advance unless a result waits
	assign en = !(out_valid && out_stall);

	tens_issue u_issue (
		.clk, .arst_n, .en, .in_valid, .in_stall,
		.ax, .ay, .az, .bx, .by, .bz, .cx, .cy, .cz,
		.tag_s1, .a_s1
	);

	tens_cross u_cross (
		.clk, .arst_n, .en, .tag_i(tag_s1), .a_i(a_s1), .tag_o(tag_cr), .w_o(w_cr)
	);

	tens_norm u_norm (
		.clk, .arst_n, .en, .tag_i(tag_cr), .w_i(w_cr),
		.tag_o(tag_nm), .nv_o(nv_nm), .sum_o(sum_nm)
	);

	tens_sqrt u_sqrt (
		.clk, .arst_n, .en, .tag_i(tag_nm), .nv_i(nv_nm), .sum_i(sum_nm),
		.tag_o(tag_sq), .nv_o(nv_sq), .root_o(root_sq)
	);

	tens_div u_div (
		.clk, .arst_n, .en, .tag_i(tag_sq), .nv_i(nv_sq), .root_i(root_sq),
		.tag_o(tag_dv), .neg_o(neg_dv), .deg_o(deg_dv), .q_o(q_dv)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= tag_dv.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			edge_index <= tag_dv.side.idx;
			edge_x     <= tag_dv.side.b.x;
			edge_y     <= tag_dv.side.b.y;
			edge_z     <= tag_dv.side.b.z;
			normal_x   <= signed_normal(q_dv[0], neg_dv[0], deg_dv);
			normal_y   <= signed_normal(q_dv[1], neg_dv[1], deg_dv);
			normal_z   <= signed_normal(q_dv[2], neg_dv[2], deg_dv);
			degenerate <= deg_dv;
			last       <= (tag_dv.side.idx == LAST_E);
		end
	end

	// a transferred triangle keeps the buffer busy for its remaining edges
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("triangle taken while previous edges still pending");

	// edges of one triangle leave back to back
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=>
		out_valid && edge_index == 2'($past(edge_index) + 2'd1))
		else $error("edge results of a triangle not consecutive");

	// a degenerate result carries a zero normal
	a_deg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
		else $error("degenerate result with nonzero normal");

endmodule
`default_nettype wire
